// ----- sv/fiv_pkg.sv -----
// Shared types, constants and the CRC byte function of the firmware image verifier.
`timescale 1ns / 1ps

package fiv_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
    localparam int WORD_W       = 32;
    localparam int CFG_IDX_W    = 3;

    localparam logic [WORD_W-1:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MAGIC_RESET = 32'hB007_10AD;
    localparam logic [WORD_W-1:0] THUMB_BIT   = 32'h0000_0001;

    localparam logic [WORD_W-1:0] APP_START_RESET = 32'h0800_4400;
    localparam logic [WORD_W-1:0] APP_END_RESET   = 32'h0801_0000;
    localparam logic [WORD_W-1:0] SRAM_LOW_RESET  = 32'h2000_0000;
    localparam logic [WORD_W-1:0] SRAM_HIGH_RESET = 32'h2000_5000;

    typedef enum logic [1:0] {
        CMD_HDR_BYTE = 2'd0,
        CMD_APP      = 2'd1,
        CMD_CHECK    = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SEQUENCE  = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_SIZE_ZERO = 4'd3,
        ST_SIZE_BIG  = 4'd4,
        ST_ERASED    = 4'd5,
        ST_STACK     = 4'd6,
        ST_THUMB     = 4'd7,
        ST_ENTRY     = 4'd8,
        ST_IMAGE     = 4'd9
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC     = 3'd0,
        CFG_APP_START = 3'd1,
        CFG_APP_END   = 3'd2,
        CFG_SRAM_LOW  = 3'd3,
        CFG_SRAM_HIGH = 3'd4
    } t_cfg_idx;

    // Reflected CRC-32 update over one byte, eight shift steps.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/fiv_in_if.sv -----
// Input channel interface: one command beat with its image byte.
`timescale 1ns / 1ps

interface fiv_in_if;
    logic             valid;
    logic             ready;
    fiv_pkg::t_cmd    command;
    logic [7:0]       data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ----- sv/fiv_out_if.sv -----
// Result channel interface: one verdict beat per check command.
`timescale 1ns / 1ps

interface fiv_out_if;
    logic             valid;
    logic             ready;
    logic             image_ok;
    fiv_pkg::t_status status;
    logic             crc_mismatch;
    logic [31:0]      computed_crc;

    modport source (output valid, output image_ok, output status, output crc_mismatch,
                    output computed_crc, input ready);
    modport sink   (input valid, input image_ok, input status, input crc_mismatch,
                    input computed_crc, output ready);
endinterface

// ----- sv/firmware_image_verifier_core.sv -----
// Top level of the firmware image verifier: header capture, CRC-32 and verdict logic.
// A check beat is held in the input register, and its verdict is registered in the output register.
// Throughput: one input beat per cycle; bytes stall only behind a check that is waiting.
// A check beat waits in the input register only while an earlier verdict is not taken.
// The CRC update of one byte is an eight-step unrolled network between the input register and the CRC register.
// Reset (synchronous, active low) loads the register defaults and clears all image state.
`timescale 1ns / 1ps

module firmware_image_verifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fiv_in_if.sink                             i_item,
    fiv_out_if.source                          o_result,
    input  logic                               i_cfg_we,
    input  logic [fiv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fiv_pkg::WORD_W-1:0]         i_cfg_data
);
    import fiv_pkg::*;

    logic [WORD_W-1:0] r_exp_magic;
    logic [WORD_W-1:0] r_app_start;
    logic [WORD_W-1:0] r_app_end;
    logic [WORD_W-1:0] r_sram_low;
    logic [WORD_W-1:0] r_sram_high;

    logic              r_in_valid;
    t_cmd              r_in_cmd;
    logic [7:0]        r_in_byte;

    logic [HDR_CNT_W-1:0] r_hdr_cnt;
    logic [WORD_W-1:0]    r_magic;
    logic [WORD_W-1:0]    r_size;
    logic [WORD_W-1:0]    r_stored_crc;
    logic [WORD_W-1:0]    r_app_cnt;
    logic [WORD_W-1:0]    r_crc;
    logic [WORD_W-1:0]    r_stack;
    logic [WORD_W-1:0]    r_reset_vec;
    logic                 r_seq_err;

    logic              r_out_valid;
    logic              r_out_ok;
    t_status           r_out_status;
    logic              r_out_mismatch;
    logic [WORD_W-1:0] r_out_crc;

    logic              out_free;
    logic              s2_go;
    logic              hdr_done;
    logic [4:0]        lane_sh;
    logic [4:0]        app_sh;
    logic [WORD_W-1:0] hdr_lane;
    logic [WORD_W-1:0] app_lane;
    logic [WORD_W-1:0] final_crc;
    logic [WORD_W-1:0] max_size;
    logic [WORD_W-1:0] entry;
    t_status           n_status;
    logic              n_mismatch;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s2_go        = r_in_valid && ((r_in_cmd != CMD_CHECK) || out_free);
    assign i_item.ready = !r_in_valid || s2_go;

    assign hdr_done = (r_hdr_cnt >= HDR_CNT_W'(HEADER_BYTES));
    assign lane_sh  = {r_hdr_cnt[1:0], 3'd0};
    assign app_sh   = {r_app_cnt[1:0], 3'd0};
    assign hdr_lane = {24'd0, r_in_byte} << lane_sh;
    assign app_lane = {24'd0, r_in_byte} << app_sh;

    assign final_crc = r_crc ^ ALL_ONES;
    assign max_size  = (r_app_end > r_app_start) ? (r_app_end - r_app_start) : '0;
    assign entry     = r_reset_vec & ~THUMB_BIT;

    always_comb begin
        n_mismatch = 1'b0;
        if (r_seq_err || !hdr_done) begin
            n_status = ST_SEQUENCE;
        end else if (r_magic != r_exp_magic) begin
            n_status = ST_MAGIC;
        end else if (r_size == '0) begin
            n_status = ST_SIZE_ZERO;
        end else if (r_size > max_size) begin
            n_status = ST_SIZE_BIG;
        end else if (r_stack == ALL_ONES || r_reset_vec == ALL_ONES) begin
            n_status = ST_ERASED;
        end else if (r_stack < r_sram_low || r_stack > r_sram_high) begin
            n_status = ST_STACK;
        end else if ((r_reset_vec & THUMB_BIT) == '0) begin
            n_status = ST_THUMB;
        end else if (entry < r_app_start || entry >= r_app_end) begin
            n_status = ST_ENTRY;
        end else if (r_app_cnt < r_size) begin
            n_status = ST_IMAGE;
        end else if (final_crc != r_stored_crc) begin
            n_status   = ST_IMAGE;
            n_mismatch = 1'b1;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic <= MAGIC_RESET;
            r_app_start <= APP_START_RESET;
            r_app_end   <= APP_END_RESET;
            r_sram_low  <= SRAM_LOW_RESET;
            r_sram_high <= SRAM_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAGIC:     r_exp_magic <= i_cfg_data;
                CFG_APP_START: r_app_start <= i_cfg_data;
                CFG_APP_END:   r_app_end   <= i_cfg_data;
                CFG_SRAM_LOW:  r_sram_low  <= i_cfg_data;
                CFG_SRAM_HIGH: r_sram_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (s2_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_cmd  <= i_item.command;
            r_in_byte <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_magic      <= '0;
            r_size       <= '0;
            r_stored_crc <= '0;
            r_app_cnt    <= '0;
            r_crc        <= ALL_ONES;
            r_stack      <= '0;
            r_reset_vec  <= '0;
            r_seq_err    <= 1'b0;
        end else if (s2_go) begin
            case (r_in_cmd)
                CMD_HDR_BYTE: begin
                    if (hdr_done || r_app_cnt != '0) begin
                        r_seq_err <= 1'b1;
                    end else begin
                        case (r_hdr_cnt[3:2])
                            2'd0:    r_magic      <= r_magic | hdr_lane;
                            2'd1:    r_size       <= r_size | hdr_lane;
                            2'd2:    r_stored_crc <= r_stored_crc | hdr_lane;
                            default: begin
                            end
                        endcase
                        r_hdr_cnt <= r_hdr_cnt + 1'b1;
                    end
                end
                CMD_APP: begin
                    if (!hdr_done) begin
                        r_seq_err <= 1'b1;
                    end else begin
                        if (r_app_cnt < 32'd4) begin
                            r_stack <= r_stack | app_lane;
                        end else if (r_app_cnt < 32'd8) begin
                            r_reset_vec <= r_reset_vec | app_lane;
                        end
                        if (r_app_cnt < r_size) begin
                            r_crc <= crc_byte(r_crc, r_in_byte);
                        end
                        if (r_app_cnt != ALL_ONES) begin
                            r_app_cnt <= r_app_cnt + 1'b1;
                        end
                    end
                end
                CMD_CHECK: begin
                    r_hdr_cnt    <= '0;
                    r_magic      <= '0;
                    r_size       <= '0;
                    r_stored_crc <= '0;
                    r_app_cnt    <= '0;
                    r_crc        <= ALL_ONES;
                    r_stack      <= '0;
                    r_reset_vec  <= '0;
                    r_seq_err    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && r_in_cmd == CMD_CHECK) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_in_cmd == CMD_CHECK) begin
            r_out_ok       <= (n_status == ST_OK);
            r_out_status   <= n_status;
            r_out_mismatch <= n_mismatch;
            r_out_crc      <= final_crc;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.image_ok     = r_out_ok;
    assign o_result.status       = r_out_status;
    assign o_result.crc_mismatch = r_out_mismatch;
    assign o_result.computed_crc = r_out_crc;

    // A processed check leaves the image state fully cleared.
    a_check_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_in_cmd == CMD_CHECK) |=>
            (r_hdr_cnt == '0 && r_app_cnt == '0 && r_crc == ALL_ONES && !r_seq_err))
        else $error("image state not cleared after check");

    // The header counter never runs past the header length.
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= HDR_CNT_W'(HEADER_BYTES))
        else $error("header counter out of range");

    // A pending verdict that is not taken blocks a following check in the input register.
    a_check_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready && r_in_valid && r_in_cmd == CMD_CHECK) |=>
            (r_in_valid && r_in_cmd == CMD_CHECK && r_out_valid))
        else $error("check beat lost while verdict pending");

    // The mismatch flag only accompanies the short-image or CRC status.
    a_mismatch_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mismatch) |-> (r_out_status == ST_IMAGE && !r_out_ok))
        else $error("crc mismatch with wrong status");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the firmware image verifier core.
`timescale 1ns / 1ps

module tb_top;
    import fiv_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_image_beat;

    typedef struct {
        logic        ok;
        t_status     st;
        logic        mism;
        logic [31:0] crc;
    } t_verdict;

    typedef enum int {
        SEQ_NONE,
        SEQ_EARLY_APP,
        SEQ_SHORT_HDR,
        SEQ_LATE_HDR
    } t_seq_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0] i_cfg_data;

    fiv_in_if  in_bus ();
    fiv_out_if out_bus ();

    firmware_image_verifier_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_bus),
        .o_result    (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register copies and image state of the verdict predictor.
    logic [31:0] cfg_magic  = MAGIC_RESET;
    logic [31:0] cfg_app_lo = APP_START_RESET;
    logic [31:0] cfg_app_hi = APP_END_RESET;
    logic [31:0] cfg_ram_lo = SRAM_LOW_RESET;
    logic [31:0] cfg_ram_hi = SRAM_HIGH_RESET;

    int          hdr_cnt;
    logic [31:0] img_magic;
    logic [31:0] img_size;
    logic [31:0] img_crc;
    logic [31:0] app_cnt;
    logic [31:0] crc_acc;
    logic [31:0] sp_word;
    logic [31:0] pc_word;
    logic        seq_err;

    t_image_beat pending_beats[$];
    t_verdict    expected_verdicts[$];
    int          n_items;
    int          n_checks;
    int          n_errors;
    int          cycles;

    logic in_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rdy_hold = 0;
    int   rdy_period = 1;
    int   rdy_duty = 1;
    int   rdy_pos = 0;

    function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] pick_between(input logic [31:0] lo, input logic [31:0] hi);
        logic [63:0] span;
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return lo + 32'({32'd0, $urandom} % span);
        endcase
    endfunction

    task automatic clear_image();
        hdr_cnt   = 0;
        img_magic = '0;
        img_size  = '0;
        img_crc   = '0;
        app_cnt   = '0;
        crc_acc   = ALL_ONES;
        sp_word   = '0;
        pc_word   = '0;
        seq_err   = 1'b0;
    endtask

    task automatic absorb_beat(input logic [1:0] cmd, input logic [7:0] b);
        t_verdict    v;
        logic [31:0] max_size;
        logic [31:0] entry;
        case (cmd)
            CMD_HDR_BYTE: begin
                if (hdr_cnt >= HEADER_BYTES || app_cnt != 32'd0) begin
                    seq_err = 1'b1;
                end else begin
                    case (hdr_cnt / 4)
                        0: img_magic[8*(hdr_cnt%4) +: 8] = b;
                        1: img_size[8*(hdr_cnt%4) +: 8] = b;
                        2: img_crc[8*(hdr_cnt%4) +: 8] = b;
                        default: ;
                    endcase
                    hdr_cnt++;
                end
            end
            CMD_APP: begin
                if (hdr_cnt < HEADER_BYTES) begin
                    seq_err = 1'b1;
                end else begin
                    if (app_cnt < 4) begin
                        sp_word[8*app_cnt[1:0] +: 8] = b;
                    end else if (app_cnt < 8) begin
                        pc_word[8*app_cnt[1:0] +: 8] = b;
                    end
                    if (app_cnt < img_size) begin
                        crc_acc = crc32_update(crc_acc, b);
                    end
                    if (app_cnt != ALL_ONES) begin
                        app_cnt++;
                    end
                end
            end
            CMD_CHECK: begin
                v.crc    = crc_acc ^ ALL_ONES;
                v.mism   = 1'b0;
                max_size = (cfg_app_hi > cfg_app_lo) ? cfg_app_hi - cfg_app_lo : 32'd0;
                entry    = pc_word & ~THUMB_BIT;
                if (seq_err || hdr_cnt < HEADER_BYTES) begin
                    v.st = ST_SEQUENCE;
                end else if (img_magic != cfg_magic) begin
                    v.st = ST_MAGIC;
                end else if (img_size == 32'd0) begin
                    v.st = ST_SIZE_ZERO;
                end else if (img_size > max_size) begin
                    v.st = ST_SIZE_BIG;
                end else if (sp_word == ALL_ONES || pc_word == ALL_ONES) begin
                    v.st = ST_ERASED;
                end else if (sp_word < cfg_ram_lo || sp_word > cfg_ram_hi) begin
                    v.st = ST_STACK;
                end else if ((pc_word & THUMB_BIT) == 32'd0) begin
                    v.st = ST_THUMB;
                end else if (entry < cfg_app_lo || entry >= cfg_app_hi) begin
                    v.st = ST_ENTRY;
                end else if (app_cnt < img_size) begin
                    v.st = ST_IMAGE;
                end else if (v.crc != img_crc) begin
                    v.st   = ST_IMAGE;
                    v.mism = 1'b1;
                end else begin
                    v.st = ST_OK;
                end
                v.ok = (v.st == ST_OK);
                expected_verdicts.push_back(v);
                clear_image();
            end
            default: ;
        endcase
    endtask

    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] b);
        t_image_beat item;
        item.cmd  = cmd;
        item.data = b;
        pending_beats.push_back(item);
        if (cmd != CMD_UNUSED) begin
            n_items++;
        end
        if (cmd == CMD_CHECK) begin
            n_checks++;
        end
    endtask

    task automatic push_image(input logic [31:0] magic, input logic [31:0] size,
                              input logic [31:0] sp, input logic [31:0] pc, input int n,
                              input bit crc_bad, input t_seq_fault fault);
        logic [7:0]   app[$];
        logic [127:0] hdr;
        logic [31:0]  acc;
        int           cut;
        int           k;
        acc = ALL_ONES;
        for (int i = 0; i < n; i++) begin
            if (i < 4) begin
                app.push_back(sp[8*i +: 8]);
            end else if (i < 8) begin
                app.push_back(pc[8*(i-4) +: 8]);
            end else begin
                app.push_back(8'($urandom));
            end
            if (i < size) begin
                acc = crc32_update(acc, app[i]);
            end
        end
        acc = acc ^ ALL_ONES;
        if (crc_bad) begin
            acc = acc ^ (32'd1 << $urandom_range(0, 31));
        end
        hdr = {32'($urandom), acc, size, magic};
        cut = (fault == SEQ_SHORT_HDR) ? $urandom_range(0, HEADER_BYTES - 1) : HEADER_BYTES;
        k   = (fault == SEQ_EARLY_APP) ? $urandom_range(0, HEADER_BYTES - 1) : -1;
        for (int j = 0; j < cut; j++) begin
            if (j == k) begin
                push_beat(CMD_APP, 8'($urandom));
            end
            push_beat(CMD_HDR_BYTE, hdr[8*j +: 8]);
        end
        if (fault != SEQ_SHORT_HDR) begin
            k = (fault == SEQ_LATE_HDR) ? $urandom_range(0, n) : -1;
            for (int j = 0; j <= n; j++) begin
                if (j == k) begin
                    push_beat(CMD_HDR_BYTE, 8'($urandom));
                end
                if (j < n) begin
                    push_beat(CMD_APP, app[j]);
                end
            end
        end
        push_beat(CMD_CHECK, 8'($urandom));
    endtask

    task automatic gen_image();
        int          flaw;
        int          n;
        logic [31:0] magic;
        logic [31:0] size;
        logic [31:0] sp;
        logic [31:0] pc;
        logic [31:0] max_size;
        t_seq_fault  fault;
        flaw     = $urandom_range(0, 19);
        fault    = SEQ_NONE;
        max_size = (cfg_app_hi > cfg_app_lo) ? cfg_app_hi - cfg_app_lo : 32'd0;
        magic    = cfg_magic;
        size     = $urandom_range(1, 16);
        if (max_size != 0 && size > max_size) begin
            size = max_size;
        end
        sp = (cfg_ram_lo <= cfg_ram_hi) ? pick_between(cfg_ram_lo, cfg_ram_hi) : $urandom;
        pc = ((max_size != 0) ? pick_between(cfg_app_lo, cfg_app_hi - 1) : $urandom) | THUMB_BIT;
        n  = ((size > 8) ? size : 8) + $urandom_range(0, 3);
        case (flaw)
            7: magic = magic ^ (32'd1 << $urandom_range(0, 31));
            8: size = 32'd0;
            9: size = max_size + 32'd1 + $urandom_range(0, 3);
            10: begin
                if ($urandom_range(0, 1)) begin
                    sp = ALL_ONES;
                end else begin
                    pc = ALL_ONES;
                end
            end
            11: sp = $urandom_range(0, 1) ? cfg_ram_hi + 32'd1 : cfg_ram_lo - 32'd1;
            12: pc = pc & ~THUMB_BIT;
            13: pc = ($urandom_range(0, 1) ? cfg_app_hi : cfg_app_lo - 32'd2) | THUMB_BIT;
            14: begin
                size = $urandom_range(9, 20);
                if (max_size != 0 && size > max_size) begin
                    size = max_size;
                end
                n = (size > 8) ? $urandom_range(8, size - 1) : 0;
            end
            15: begin
                size = $urandom_range(1, 7);
                n    = $urandom_range(0, 10);
            end
            17: fault = SEQ_EARLY_APP;
            18: fault = SEQ_SHORT_HDR;
            19: fault = SEQ_LATE_HDR;
            default: ;
        endcase
        push_image(magic, size, sp, pc, n, flaw == 16, fault);
    endtask

    task automatic run_random(input int min_items, input int min_checks);
        int items0;
        int checks0;
        items0  = n_items;
        checks0 = n_checks;
        while (n_items - items0 < min_items || n_checks - checks0 < min_checks) begin
            case ($urandom_range(0, 11))
                0: push_beat(CMD_UNUSED, 8'($urandom));
                1: push_beat(CMD_CHECK, 8'($urandom));
                default: gen_image();
            endcase
        end
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_MAGIC:     cfg_magic  = value;
            CFG_APP_START: cfg_app_lo = value;
            CFG_APP_END:   cfg_app_hi = value;
            CFG_SRAM_LOW:  cfg_ram_lo = value;
            CFG_SRAM_HIGH: cfg_ram_hi = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [31:0] app_lo,
                              input logic [31:0] app_hi, input logic [31:0] ram_lo,
                              input logic [31:0] ram_hi);
        wait_idle();
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_APP_START, app_lo);
        write_reg(CFG_APP_END, app_hi);
        write_reg(CFG_SRAM_LOW, ram_lo);
        write_reg(CFG_SRAM_HIGH, ram_hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input t_verdict want, input t_verdict got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s: expected ok=%0b status=%0d mism=%0b crc=%h", what,
                     want.ok, want.st, want.mism, want.crc);
            $display("    got ok=%0b status=%0d mism=%0b crc=%h",
                     got.ok, got.st, got.mism, got.crc);
        end
    endtask

    // Monitor: predicts on accepted input beats and checks verdict beats.
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            if (i_rst_n && out_bus.valid && out_bus.ready) begin
                got.ok   = out_bus.image_ok;
                got.st   = out_bus.status;
                got.mism = out_bus.crc_mismatch;
                got.crc  = out_bus.computed_crc;
                if (expected_verdicts.size() == 0) begin
                    want = '{1'b0, ST_OK, 1'b0, 32'd0};
                    note_mismatch("unexpected verdict", want, got);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.ok !== want.ok || got.st !== want.st ||
                        got.mism !== want.mism || got.crc !== want.crc) begin
                        note_mismatch("verdict mismatch", want, got);
                    end
                end
            end
            in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
            if (i_rst_n && in_bus.valid && in_bus.ready) begin
                absorb_beat(in_bus.command, in_bus.data_byte);
            end
        end
    end

    // Driver: sends pending beats in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (in_taken) begin
            void'(pending_beats.pop_front());
        end
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
                in_bus.valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
            end else begin
                in_bus.valid     <= 1'b1;
                in_bus.command   <= t_cmd'(pending_beats[0].cmd);
                in_bus.data_byte <= pending_beats[0].data;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: ready follows a duty pattern of random period and duty, redrawn whenever its hold counter runs out.
    always @(negedge i_clk) begin
        if (rdy_hold == 0) begin
            rdy_hold   = 40;
            rdy_period = $urandom_range(1, 6);
            rdy_duty   = ($urandom_range(0, 2) == 0) ? rdy_period : $urandom_range(0, rdy_period);
        end
        rdy_hold--;
        rdy_pos = (rdy_pos + 1) % rdy_period;
        out_bus.ready <= i_rst_n && (rdy_pos < rdy_duty);
    end

    initial begin
        logic [31:0] base;
        in_bus.valid     = 1'b0;
        in_bus.command   = CMD_HDR_BYTE;
        in_bus.data_byte = 8'd0;
        out_bus.ready    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        n_items          = 0;
        n_checks         = 0;
        n_errors         = 0;
        cycles           = 0;
        clear_image();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(CMD_CHECK, 8'h00);
        push_beat(CMD_UNUSED, 8'hFF);
        push_beat(CMD_APP, 8'h5A);
        push_beat(CMD_CHECK, 8'hFF);
        push_image(MAGIC_RESET, 32'd8, SRAM_HIGH_RESET, APP_START_RESET | THUMB_BIT, 8, 1'b0,
                   SEQ_NONE);
        run_random(170, 8);

        base = $urandom_range(0, 32'hF000_0000);
        set_config($urandom, base, base + $urandom_range(16, 4096),
                   base ^ 32'h2000_0000, (base ^ 32'h2000_0000) + $urandom_range(0, 65536));
        run_random(170, 8);

        set_config(32'd0, 32'd0, ALL_ONES, 32'd0, ALL_ONES);
        run_random(170, 8);

        set_config(ALL_ONES, 32'h0000_1000, 32'h0000_1000, 32'h2000_0100, 32'h2000_00FF);
        run_random(120, 6);

        set_config(MAGIC_RESET, 32'hFFFF_FFF0, ALL_ONES, 32'h2000_0400, 32'h2000_0400);
        run_random(170, 8);

        wait_idle();
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/fiv_pkg.sv
sv/fiv_in_if.sv
sv/fiv_out_if.sv
sv/firmware_image_verifier_core.sv
verif/tb_top.sv
